>>> sv/fdrq_pkg.sv
// fdrq_pkg: command, status, sequencer and register codes for the frame display reorder queue
// no dependencies; used by frame_display_reorder_queue
package fdrq_pkg;

  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 6;
  localparam int HOLD_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [HOLD_W-1:0] HOLD_DEPTH_RST = 6'd18;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP     = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_HEAD,
    S_DONE
  } state_e;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE  = 2'd2;

endpackage

>>> sv/fdrq_slot_ram.sv
// fdrq_slot_ram: picture slot memory, one write and one read port, registered read data
// no dependencies; instantiated by frame_display_reorder_queue
module fdrq_slot_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 42,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/frame_display_reorder_queue.sv
// frame_display_reorder_queue: display-order queue of decoded pictures, sequencer and datapath
// depends on fdrq_pkg and fdrq_slot_ram
// The queue is a circular buffer in one slot memory with a single read and a single write
// port, walked by one timestamp comparator. One command is handled at a time; s_tready_o
// is low while it runs. An insert with a valid timestamp has the comparator walk the queue
// from the head one entry a cycle to find the insert point; when it lands in front of a
// queued entry, the entries behind it move up one slot a cycle through the memory port.
// An insert without a timestamp goes to the tail; pop and restart mark on a nonempty
// queue do one head read. The result sits in an output register, so the next command is
// taken while it waits. The memory needs no clearing.
module frame_display_reorder_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int STAMP_BITS  = 33,
  parameter int HANDLE_BITS = 8,
  localparam int IN_W       = STAMP_BITS + HANDLE_BITS + 2,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = STAMP_BITS + HANDLE_BITS + 3 + fdrq_pkg::FILL_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fdrq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fdrq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // pts, pts_valid, frame_handle, decode_ok
  input  logic [IN_TDATA_W-1:0]            s_tdata_i,
  // command
  input  logic [fdrq_pkg::CMD_W-1:0]       s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // out_pts, out_pts_valid, out_handle, dropped, picture_ready, fill_level
  output logic [OUT_TDATA_W-1:0]           m_tdata_o,
  // status
  output logic [fdrq_pkg::STATUS_W-1:0]    m_tuser_o
);

  import fdrq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int SLOT_W = STAMP_BITS + 1 + HANDLE_BITS;
  localparam int CMP_W  = (CNT_W > HOLD_W) ? CNT_W : HOLD_W;

  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // input beat fields
  logic [STAMP_BITS-1:0]  in_pts;
  logic                   in_pv;
  logic [HANDLE_BITS-1:0] in_hdl;
  logic                   in_ok;
  cmd_e                   in_cmd;
  logic                   in_acc;

  assign in_pts = s_tdata_i[STAMP_BITS-1:0];
  assign in_pv  = s_tdata_i[STAMP_BITS];
  assign in_hdl = s_tdata_i[STAMP_BITS+HANDLE_BITS:STAMP_BITS+1];
  assign in_ok  = s_tdata_i[STAMP_BITS+HANDLE_BITS+1];
  assign in_cmd = cmd_e'(s_tuser_i);

  state_e state_q, state_d;

  cmd_e                   cmd_q, cmd_d;
  logic [STAMP_BITS-1:0]  pts_q, pts_d;
  logic                   pv_q, pv_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             lag_vld_q, lag_vld_d;
  logic [CNT_W-1:0] lag_idx_q, lag_idx_d;

  logic                  rs_pend_q, rs_pend_d;
  logic [STAMP_BITS-1:0] rs_pts_q, rs_pts_d;
  logic                  rs_vld_q, rs_vld_d;

  logic [HOLD_W-1:0] hold_q;
  logic              drain_q, drop_q;
  logic              mode_clr;

  status_e                res_status_q, res_status_d;
  logic [STAMP_BITS-1:0]  res_pts_q, res_pts_d;
  logic                   res_pv_q, res_pv_d;
  logic [HANDLE_BITS-1:0] res_hdl_q, res_hdl_d;
  logic                   res_drop_q, res_drop_d;

  logic                   out_vld_q, out_vld_d;
  logic                   out_load;
  status_e                out_status_q;
  logic [STAMP_BITS-1:0]  out_pts_q;
  logic                   out_pv_q;
  logic [HANDLE_BITS-1:0] out_hdl_q;
  logic                   out_drop_q;
  logic                   out_ready_q;
  logic [FILL_W-1:0]      out_fill_q;
  logic                   ready_now;

  // slot memory port
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [SLOT_W-1:0] wr_data, rd_data;

  logic [STAMP_BITS-1:0]  rd_pts;
  logic                   rd_pv;
  logic [HANDLE_BITS-1:0] rd_hdl;

  assign rd_pts = rd_data[STAMP_BITS-1:0];
  assign rd_pv  = rd_data[STAMP_BITS];
  assign rd_hdl = rd_data[SLOT_W-1:STAMP_BITS+1];

  // shared timestamp comparator
  logic [STAMP_BITS-1:0] cmp_b;
  logic                  cmp_gt, cmp_eq;

  assign cmp_b  = (cmd_q == CMD_POP) ? rs_pts_q : pts_q;
  assign cmp_gt = rd_pts > cmp_b;
  assign cmp_eq = rd_pts == cmp_b;

  logic hit, search_end, shift_end, match;

  assign hit        = lag_vld_q && rd_pv && cmp_gt;
  assign search_end = hit || (idx_q == count_q);
  assign shift_end  = !lag_vld_q && (idx_q == pos_q);
  assign match      = (rd_pv == rs_vld_q) && (!rd_pv || cmp_eq);

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign out_load   = (state_q == S_DONE) && (!out_vld_q || m_tready_i);

  fdrq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SLOT_W),
    .ADDR_W(PTR_W)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_INSERT: begin
              if (!in_ok || (count_q == CNT_W'(QUEUE_DEPTH))) begin
                state_d = S_DONE;
              end else if (in_pv) begin
                state_d = S_SEARCH;
              end else begin
                state_d = S_SHIFT;
              end
            end
            CMD_POP, CMD_RESTART: begin
              state_d = (count_q != '0) ? S_HEAD : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SEARCH: if (search_end) state_d = S_SHIFT;
      S_SHIFT:  if (shift_end) state_d = S_DONE;
      S_HEAD:   state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d        = cmd_q;
    pts_d        = pts_q;
    pv_d         = pv_q;
    hdl_d        = hdl_q;
    count_d      = count_q;
    head_d       = head_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    lag_vld_d    = 1'b0;
    lag_idx_d    = lag_idx_q;
    rs_pend_d    = rs_pend_q;
    rs_pts_d     = rs_pts_q;
    rs_vld_d     = rs_vld_q;
    res_status_d = res_status_q;
    res_pts_d    = res_pts_q;
    res_pv_d     = res_pv_q;
    res_hdl_d    = res_hdl_q;
    res_drop_d   = res_drop_q;
    mode_clr     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    wr_data      = rd_data;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d        = in_cmd;
          pts_d        = in_pts;
          pv_d         = in_pv;
          hdl_d        = in_hdl;
          res_status_d = ST_OK;
          res_pts_d    = '0;
          res_pv_d     = 1'b0;
          res_hdl_d    = '0;
          res_drop_d   = 1'b0;
          idx_d        = '0;
          pos_d        = count_q;
          case (in_cmd)
            CMD_INSERT: begin
              if (!in_ok) begin
                res_status_d = ST_IGNORED;
              end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_status_d = ST_FULL;
              end else if (!in_pv) begin
                idx_d = count_q;
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en = 1'b1;
              end
            end
            CMD_FLUSH: begin
              count_d  = '0;
              mode_clr = 1'b1;
            end
            CMD_RESTART: begin
              rs_pend_d = 1'b1;
              if (count_q == '0) begin
                rs_pts_d = in_pts;
                rs_vld_d = in_pv;
              end else begin
                rd_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        // one read issued per cycle; the compare works on the registered data of the previous read
        if (search_end) begin
          pos_d = hit ? lag_idx_q : count_q;
          idx_d = count_q;
        end else begin
          rd_en     = (idx_q < count_q);
          rd_addr   = phys(head_q, idx_q);
          lag_vld_d = rd_en;
          lag_idx_d = idx_q;
          idx_d     = idx_q + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        // move entries up from the tail, one read and one write per cycle
        if (lag_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_q, lag_idx_q);
          wr_data = rd_data;
        end else if (idx_q == pos_q) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_q, pos_q);
          wr_data = {hdl_q, pv_q, pts_q};
          count_d = count_q + CNT_W'(1);
        end
        if (idx_q > pos_q) begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_q, idx_q - CNT_W'(1));
          lag_vld_d = 1'b1;
          lag_idx_d = idx_q;
          idx_d     = idx_q - CNT_W'(1);
        end
      end
      S_HEAD: begin
        if (cmd_q == CMD_POP) begin
          res_pts_d  = rd_pts;
          res_pv_d   = rd_pv;
          res_hdl_d  = rd_hdl;
          res_drop_d = drop_q;
          if (rs_pend_q) begin
            if (match) begin
              rs_pend_d = 1'b0;
            end else begin
              res_drop_d = 1'b1;
            end
          end
          head_d  = phys(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end else begin
          rs_pts_d = rd_pts;
          rs_vld_d = rd_pv;
        end
      end
      default: ;
    endcase
  end

  assign ready_now = drain_q ? (count_q != '0) : (CMP_W'(count_q) >= CMP_W'(hold_q));

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      lag_vld_q <= 1'b0;
      rs_pend_q <= 1'b0;
      rs_pts_q  <= '0;
      rs_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      lag_vld_q <= lag_vld_d;
      rs_pend_q <= rs_pend_d;
      rs_pts_q  <= rs_pts_d;
      rs_vld_q  <= rs_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_DEPTH_RST;
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else if (mode_clr) begin
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOLD_DEPTH: hold_q  <= cfg_data_i[HOLD_W-1:0];
        CFG_DRAIN_MODE: drain_q <= cfg_data_i[0];
        CFG_DROP_MODE:  drop_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pts_q        <= pts_d;
    pv_q         <= pv_d;
    hdl_q        <= hdl_d;
    lag_idx_q    <= lag_idx_d;
    res_status_q <= res_status_d;
    res_pts_q    <= res_pts_d;
    res_pv_q     <= res_pv_d;
    res_hdl_q    <= res_hdl_d;
    res_drop_q   <= res_drop_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pts_q    <= res_pts_q;
      out_pv_q     <= res_pv_q;
      out_hdl_q    <= res_hdl_q;
      out_drop_q   <= res_drop_q;
      out_ready_q  <= ready_now;
      out_fill_q   <= FILL_W'(count_q);
    end
  end

  always_comb begin
    m_tdata_o = '0;
    m_tdata_o[STAMP_BITS-1:0]                       = out_pts_q;
    m_tdata_o[STAMP_BITS]                           = out_pv_q;
    m_tdata_o[STAMP_BITS+HANDLE_BITS:STAMP_BITS+1]  = out_hdl_q;
    m_tdata_o[STAMP_BITS+HANDLE_BITS+1]             = out_drop_q;
    m_tdata_o[STAMP_BITS+HANDLE_BITS+2]             = out_ready_q;
    m_tdata_o[OUT_W-1:STAMP_BITS+HANDLE_BITS+3]     = out_fill_q;
  end

  assign m_tuser_o  = out_status_q;
  assign m_tvalid_o = out_vld_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_tready_o)
    else $error("input taken while a command is in progress");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == ST_FULL)) |-> (out_fill_q == FILL_W'(QUEUE_DEPTH)))
    else $error("full status with queue not full");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == ST_EMPTY)) |-> (out_fill_q == '0))
    else $error("empty status with queue not empty");

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for frame_display_reorder_queue, stream in/out with random idling
// depends on fdrq_pkg and the queue rtl; predicts each reply with its own queue model, except typed directed rows
// directed command table first, then phases of random traffic under varying register settings
`timescale 1ns / 1ps

module tb_top;
  import fdrq_pkg::*;

  localparam int DEPTH      = 32;
  localparam int STAMP_W    = 33;
  localparam int HANDLE_W   = 8;
  localparam int IN_TW      = 48;
  localparam int OUT_TW     = 56;
  localparam int ITEM_GOAL  = 1850;
  localparam int DOG_LIMIT  = 4000;
  localparam int DIR_ROWS   = 20;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  typedef struct packed {
    status_e               status;
    logic [STAMP_W-1:0]    pts;
    logic                  pts_valid;
    logic [HANDLE_W-1:0]   handle;
    logic                  dropped;
    logic                  ready;
    logic [FILL_W-1:0]     fill;
  } reply_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [STAMP_W-1:0]    pts;
    logic                  pts_valid;
    logic [HANDLE_W-1:0]   handle;
    logic                  decode_ok;
    logic                  typed;
    status_e               status;
    logic                  ready;
    logic [FILL_W-1:0]     fill;
  } dir_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [IN_TW-1:0]      s_tdata_i  = '0;
  logic [CMD_W-1:0]      s_tuser_i  = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_TW-1:0]     m_tdata_o;
  logic [STATUS_W-1:0]   m_tuser_o;

  frame_display_reorder_queue #(
    .QUEUE_DEPTH (DEPTH),
    .STAMP_BITS  (STAMP_W),
    .HANDLE_BITS (HANDLE_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the picture queue and registers
  logic [STAMP_W-1:0]  pic_stamp    [DEPTH];
  logic                pic_stamp_ok [DEPTH];
  logic [HANDLE_W-1:0] pic_buf      [DEPTH];
  int                  pic_count    = 0;
  logic                restart_armed = 1'b0;
  logic [STAMP_W-1:0]  restart_ts    = '0;
  logic                restart_ts_ok = 1'b0;
  logic [HOLD_W-1:0]   hold_cfg      = HOLD_DEPTH_RST;
  logic                drain_cfg     = 1'b0;
  logic                drop_cfg      = 1'b0;

  reply_t      predicted_replies [$];
  int          mismatches  = 0;
  int          items_done  = 0;
  int          dog_count   = 0;
  int unsigned src_mode    = 2;
  int unsigned sink_mode   = 2;
  dir_row_t    dir_rows [DIR_ROWS];

  function automatic reply_t run_command(cmd_e cmd, logic [STAMP_W-1:0] pts, logic pv,
                                         logic [HANDLE_W-1:0] hdl, logic ok);
    reply_t r;
    int     pos;
    logic   match;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (!ok) begin
          r.status = ST_IGNORED;
        end else if (pic_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = pic_count;
          if (pv) begin
            for (int i = pic_count - 1; i >= 0; i--)
              if (pic_stamp_ok[i] && pic_stamp[i] > pts) pos = i;
          end
          for (int i = pic_count; i > pos; i--) begin
            pic_stamp[i]    = pic_stamp[i-1];
            pic_stamp_ok[i] = pic_stamp_ok[i-1];
            pic_buf[i]      = pic_buf[i-1];
          end
          pic_stamp[pos]    = pts;
          pic_stamp_ok[pos] = pv;
          pic_buf[pos]      = hdl;
          pic_count++;
        end
      end
      CMD_POP: begin
        if (pic_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pts       = pic_stamp[0];
          r.pts_valid = pic_stamp_ok[0];
          r.handle    = pic_buf[0];
          for (int i = 1; i < pic_count; i++) begin
            pic_stamp[i-1]    = pic_stamp[i];
            pic_stamp_ok[i-1] = pic_stamp_ok[i];
            pic_buf[i-1]      = pic_buf[i];
          end
          pic_count--;
          r.dropped = drop_cfg;
          if (restart_armed) begin
            match = (r.pts_valid == restart_ts_ok) && (!r.pts_valid || r.pts == restart_ts);
            if (match) restart_armed = 1'b0;
            else r.dropped = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        pic_count = 0;
        drain_cfg = 1'b0;
        drop_cfg  = 1'b0;
      end
      default: begin
        restart_armed = 1'b1;
        if (pic_count > 0) begin
          restart_ts    = pic_stamp[0];
          restart_ts_ok = pic_stamp_ok[0];
        end else begin
          restart_ts    = pts;
          restart_ts_ok = pv;
        end
      end
    endcase
    r.ready = drain_cfg ? (pic_count > 0) : (pic_count >= int'(hold_cfg));
    r.fill  = pic_count[FILL_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic send_cmd(cmd_e cmd, logic [STAMP_W-1:0] pts, logic pv,
                          logic [HANDLE_W-1:0] hdl, logic ok, bit typed, reply_t typed_reply);
    int unsigned gap;
    reply_t      r;
    if ($urandom_range(0, 49) == 0) src_mode = $urandom_range(0, 2);
    gap = draw_wait(src_mode);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= {5'b0, ok, hdl, pv, pts};
    @(posedge clk_i);
    while (s_tready_o !== 1'b1) @(posedge clk_i);
    r = run_command(cmd, pts, pv, hdl, ok);
    predicted_replies.push_back(typed ? typed_reply : r);
  endtask

  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_HOLD_DEPTH: hold_cfg  = data[HOLD_W-1:0];
      CFG_DRAIN_MODE: drain_cfg = data[0];
      CFG_DROP_MODE:  drop_cfg  = data[0];
      default: ;
    endcase
  endtask

  task automatic random_item(mix_e mix);
    int unsigned         w;
    int unsigned         k;
    cmd_e                cmd;
    logic [STAMP_W-1:0]  pts;
    logic                pv;
    logic                ok;
    w = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     cmd = (w < 70) ? CMD_INSERT : (w < 92) ? CMD_POP : CMD_RESTART;
      MIX_BALANCED: cmd = (w < 46) ? CMD_INSERT : (w < 90) ? CMD_POP :
                          (w < 96) ? CMD_RESTART : CMD_FLUSH;
      default:      cmd = (w < 25) ? CMD_INSERT : (w < 90) ? CMD_POP :
                          (w < 96) ? CMD_RESTART : CMD_FLUSH;
    endcase
    k = $urandom_range(0, 9);
    if (k < 6) pts = STAMP_W'($urandom_range(0, 40));
    else if (k < 8) pts = {1'($urandom_range(0, 1)), 32'($urandom())};
    else if (k == 8) pts = '0;
    else pts = STAMP_MAX;
    pv = ($urandom_range(0, 99) < 85);
    ok = ($urandom_range(0, 99) < 92);
    send_cmd(cmd, pts, pv, HANDLE_W'($urandom_range(0, 255)), ok, 1'b0, '0);
    items_done++;
  endtask

  task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_reply();
    reply_t act;
    reply_t exp_r;
    act.status = status_e'(m_tuser_o);
    {act.fill, act.ready, act.dropped, act.handle, act.pts_valid, act.pts} = m_tdata_o[49:0];
    if (predicted_replies.size() == 0) begin
      mismatches++;
      $display("%0t ns: unexpected reply beat, expected none, actual 0x%0h", $time, act);
    end else begin
      exp_r = predicted_replies.pop_front();
      cmp_field("status", 64'(exp_r.status), 64'(act.status));
      cmp_field("out_pts", 64'(exp_r.pts), 64'(act.pts));
      cmp_field("out_pts_valid", 64'(exp_r.pts_valid), 64'(act.pts_valid));
      cmp_field("out_handle", 64'(exp_r.handle), 64'(act.handle));
      cmp_field("dropped", 64'(exp_r.dropped), 64'(act.dropped));
      cmp_field("picture_ready", 64'(exp_r.ready), 64'(act.ready));
      cmp_field("fill_level", 64'(exp_r.fill), 64'(act.fill));
    end
  endtask

  // reply side with random stalls
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_mode = $urandom_range(0, 2);
      stall = draw_wait(sink_mode);
      if (stall != 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
      while (m_tvalid_o !== 1'b1) @(posedge clk_i);
      check_reply();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o === 1'b1) || (m_tvalid_o === 1'b1 && m_tready_i))
      dog_count <= 0;
    else
      dog_count <= dog_count + 1;
    if (dog_count >= DOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    reply_t      typed_r;
    mix_e        mix;
    int          phase;
    int          n;
    dir_rows = '{
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b1, ST_EMPTY,   1'b0, 6'd0},
      '{CMD_INSERT,  33'd0,     1'b1, 8'h5a, 1'b0, 1'b1, ST_IGNORED, 1'b0, 6'd0},
      '{CMD_RESTART, STAMP_MAX, 1'b1, 8'h00, 1'b1, 1'b1, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  STAMP_MAX, 1'b1, 8'hff, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd0,     1'b1, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd5,     1'b0, 8'haa, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd0,     1'b1, 8'h01, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd3,     1'b1, 8'h02, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b1, ST_EMPTY,   1'b0, 6'd0},
      '{CMD_RESTART, 33'd0,     1'b0, 8'h00, 1'b1, 1'b1, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd7,     1'b0, 8'h03, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_INSERT,  33'd9,     1'b1, 8'h04, 1'b1, 1'b0, ST_OK,      1'b0, 6'd0},
      '{CMD_FLUSH,   33'd0,     1'b0, 8'h00, 1'b1, 1'b1, ST_OK,      1'b0, 6'd0},
      '{CMD_POP,     33'd0,     1'b0, 8'h00, 1'b1, 1'b1, ST_EMPTY,   1'b0, 6'd0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers after reset
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_r        = '0;
      typed_r.status = dir_rows[i].status;
      typed_r.ready  = dir_rows[i].ready;
      typed_r.fill   = dir_rows[i].fill;
      send_cmd(dir_rows[i].cmd, dir_rows[i].pts, dir_rows[i].pts_valid, dir_rows[i].handle,
               dir_rows[i].decode_ok, dir_rows[i].typed, typed_r);
    end

    phase = 0;
    while (items_done < ITEM_GOAL) begin
      wait_idle();
      case (phase)
        0: begin
          cfg_write(CFG_HOLD_DEPTH, 6'd0);
          cfg_write(CFG_DRAIN_MODE, 6'd0);
          cfg_write(CFG_DROP_MODE, 6'd0);
          mix = MIX_BALANCED;
        end
        1: begin
          cfg_write(CFG_HOLD_DEPTH, 6'd32);
          mix = MIX_FILL;
        end
        2: begin
          cfg_write(CFG_HOLD_DEPTH, 6'd1);
          cfg_write(CFG_DRAIN_MODE, 6'd1);
          cfg_write(CFG_DROP_MODE, 6'd1);
          mix = MIX_BALANCED;
        end
        3: begin
          cfg_write(CFG_HOLD_DEPTH, 6'd63);
          cfg_write(CFG_DRAIN_MODE, 6'h3f);
          cfg_write(CFG_DROP_MODE, 6'h3e);
          cfg_write(CFG_SPARE, 6'h2a);
          mix = MIX_FILL;
        end
        default: begin
          cfg_write(CFG_HOLD_DEPTH, ($urandom_range(0, 7) == 0) ?
                    CFG_DATA_W'($urandom_range(0, 63)) : CFG_DATA_W'($urandom_range(1, 32)));
          cfg_write(CFG_DRAIN_MODE, CFG_DATA_W'($urandom_range(0, 63)));
          cfg_write(CFG_DROP_MODE, CFG_DATA_W'($urandom_range(0, 63)));
          if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 63)));
          mix = mix_e'($urandom_range(0, 2));
        end
      endcase
      cfg_we_i <= 1'b0;
      n = $urandom_range(60, 140);
      for (int j = 0; j < n && items_done < ITEM_GOAL; j++) begin
        random_item(mix);
        // now and then, hold off until the queue has answered everything
        if ($urandom_range(0, 149) == 0) begin
          s_tvalid_i <= 1'b0;
          while (predicted_replies.size() != 0) @(posedge clk_i);
        end
      end
      phase++;
    end

    s_tvalid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
